FILE: rtl/core/phs_pkg.sv
package phs_pkg;

  localparam int INT_REGS     = 32;
  localparam int FLOAT_REGS   = 16;
  localparam int FORWARD_WAIT = 2;

  localparam logic [1:0] KIND_ILLEGAL = 2'd1;
  localparam logic [1:0] KIND_SYSCALL = 2'd2;

  localparam logic [5:0] SRC_NONE = 6'd0;
  localparam logic [5:0] SRC_HI   = 6'd32;
  localparam logic [5:0] SRC_LO   = 6'd33;

  localparam logic [1:0] MEM_LOAD  = 2'd1;
  localparam logic [1:0] MEM_STORE = 2'd2;

  localparam logic [2:0] DEST_INT   = 3'd1;
  localparam logic [2:0] DEST_HI    = 3'd2;
  localparam logic [2:0] DEST_LO    = 3'd3;
  localparam logic [2:0] DEST_HILO  = 3'd4;
  localparam logic [2:0] DEST_FLOAT = 3'd5;

  localparam logic [1:0] SEL_REGFILE = 2'd0;
  localparam logic [1:0] SEL_FWD_LO  = 2'd1;
  localparam logic [1:0] SEL_FWD_HI  = 2'd2;

  typedef logic [1:0] wait_t;

  typedef struct packed {
    logic       stall_res;
    logic [1:0] src_a_select;
    logic       src_b_select;
    logic       sub_select;
    logic       bubble;
    logic       squash_fetch;
    logic       illegal;
  } res_t;

  // Counter value aged by one step (held at zero), then raised to a new latency by maximum.
  function automatic wait_t wait_dec(input wait_t w);
    wait_dec = (w != 2'd0) ? w - 2'd1 : w;
  endfunction

  function automatic wait_t wait_max(input wait_t a, input wait_t b);
    wait_max = (a > b) ? a : b;
  endfunction

endpackage

FILE: rtl/core/pipeline_hazard_scoreboard_unit.sv
// Decode-stage hazard scoreboard for a five-stage pipeline.
// Input channel (in_valid/in_ready): one pre-decoded instruction per beat.
// Result channel (out_valid/out_ready): one beat per instruction with the
// stall/bubble mark, operand bypass selects, fetch squash and illegal flag.
// The check reads the per-register wait counters and the syscall/load flags
// in the cycle the instruction is accepted; the counters update on that edge,
// so the next instruction sees them at once.
// The result is registered into the output queue when the instruction is accepted.
// One instruction is accepted per cycle while the output queue has a free
// entry; the counter bank updates on each acceptance.
// Results go through a two-entry output queue; in_ready drops only when
// both entries hold beats the receiver has not taken, so one instruction is
// still accepted while a finished result waits.
// Synchronous reset (rst_n low) clears all wait counters, the pending
// syscall and load-in-execute flags, and empties the output queue.
module pipeline_hazard_scoreboard_unit import phs_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_kind,
  input  logic [5:0] in_src_a,
  input  logic [5:0] in_src_b,
  input  logic [4:0] in_sub_src,
  input  logic       in_has_float_src,
  input  logic [3:0] in_float_src,
  input  logic [1:0] in_mem_kind,
  input  logic [2:0] in_dest_kind,
  input  logic [4:0] in_dest_reg,
  input  logic [1:0] in_result_latency,
  input  logic       in_syscall_retired,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_stall_res,
  output logic [1:0] out_src_a_select,
  output logic       out_src_b_select,
  output logic       out_sub_select,
  output logic       out_bubble,
  output logic       out_squash_fetch,
  output logic       out_illegal
);

  wait_t int_wait_r   [INT_REGS];
  wait_t float_wait_r [FLOAT_REGS];
  wait_t hilo_wait_r  [2];
  wait_t int_wait_nxt   [INT_REGS];
  wait_t float_wait_nxt [FLOAT_REGS];
  wait_t hilo_wait_nxt  [2];
  logic  syscall_pending_r, syscall_pending_nxt;
  logic  load_in_execute_r, load_in_execute_nxt;

  res_t       fifo_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r;

  logic  in_fire, out_fire;
  logic  pend, is_illegal, is_syscall, normal;
  logic  a_hi, a_lo, b_hi, b_lo;
  wait_t wa, wb, ws;
  logic  fwd_a_int, fwd_b_int, fwd_hi, fwd_lo, fwd_sub, any_fwd;
  logic  wait_a, wait_b, wait_s, wait_f;
  logic  stall;
  res_t  res;

  // Counter for one source: HI/LO first, then integers in range, else none.
  function automatic wait_t src_wait(input logic [5:0] v, input wait_t iw [INT_REGS],
                                     input wait_t hw [2]);
    wait_t w;
    w = 2'd0;
    if (v == SRC_HI) begin
      w = hw[0];
    end else if (v == SRC_LO) begin
      w = hw[1];
    end else if (v != SRC_NONE) begin
      for (int i = 0; i < INT_REGS; i++) begin
        if (32'(v) == i) w = iw[i];
      end
    end
    return w;
  endfunction

  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;
  assign in_ready  = (count_r != 2'd2);
  assign out_valid = (count_r != 2'd0);

  assign pend       = syscall_pending_r && !in_syscall_retired;
  assign is_illegal = !pend && (in_kind == KIND_ILLEGAL);
  assign is_syscall = !pend && (in_kind == KIND_SYSCALL);
  assign normal     = !pend && !is_illegal && !is_syscall;

  assign a_hi = (in_src_a == SRC_HI);
  assign a_lo = (in_src_a == SRC_LO);
  assign b_hi = (in_src_b == SRC_HI);
  assign b_lo = (in_src_b == SRC_LO);

  always_comb begin
    wa = src_wait(in_src_a, int_wait_r, hilo_wait_r);
    wb = src_wait(in_src_b, int_wait_r, hilo_wait_r);
    ws = src_wait({1'b0, in_sub_src}, int_wait_r, hilo_wait_r);
    wait_f = 1'b0;
    for (int i = 0; i < FLOAT_REGS; i++) begin
      if (in_has_float_src && 32'(in_float_src) == i && float_wait_r[i] != 2'd0) begin
        wait_f = 1'b1;
      end
    end
  end

  assign wait_a = (wa != 2'd0) && (wa != 2'(FORWARD_WAIT));
  assign wait_b = (wb != 2'd0) && (wb != 2'(FORWARD_WAIT));
  assign wait_s = (ws != 2'd0) && (ws != 2'(FORWARD_WAIT));

  always_comb begin
    fwd_a_int = 1'b0;
    fwd_b_int = 1'b0;
    fwd_hi    = 1'b0;
    fwd_lo    = 1'b0;
    fwd_sub   = 1'b0;
    if (normal) begin
      if (wa == 2'(FORWARD_WAIT)) begin
        if (a_hi)      fwd_hi = 1'b1;
        else if (a_lo) fwd_lo = 1'b1;
        else           fwd_a_int = 1'b1;
      end
      if (wb == 2'(FORWARD_WAIT)) begin
        if (b_hi)      fwd_hi = 1'b1;
        else if (b_lo) fwd_lo = 1'b1;
        else           fwd_b_int = 1'b1;
      end
      fwd_sub = (ws == 2'(FORWARD_WAIT));
    end
  end

  assign any_fwd = fwd_a_int || fwd_b_int || fwd_hi || fwd_lo || fwd_sub;

  assign stall = pend || is_syscall ||
                 (normal && (wait_a || wait_b || wait_s || wait_f ||
                  (any_fwd && (in_mem_kind == MEM_STORE || load_in_execute_r))));

  assign syscall_pending_nxt = pend || is_syscall;

  always_comb begin
    res              = '0;
    res.illegal      = is_illegal;
    res.stall_res    = stall;
    res.bubble       = stall;
    res.squash_fetch = stall && syscall_pending_nxt;
    if (!stall && !is_illegal) begin
      if (fwd_lo)         res.src_a_select = SEL_FWD_LO;
      else if (fwd_hi)    res.src_a_select = SEL_FWD_HI;
      else if (fwd_a_int) res.src_a_select = SEL_FWD_LO;
      res.src_b_select = fwd_b_int;
      res.sub_select   = fwd_sub;
    end
  end

  // Counter bank: age by one (held for an illegal instruction), then the issuing instruction claims its destination.
  always_comb begin
    for (int i = 0; i < INT_REGS; i++) begin
      int_wait_nxt[i] = is_illegal ? int_wait_r[i] : wait_dec(int_wait_r[i]);
      if (!stall && !is_illegal && in_dest_kind == DEST_INT && in_dest_reg != 5'd0 &&
          32'(in_dest_reg) == i) begin
        int_wait_nxt[i] = wait_max(int_wait_nxt[i], in_result_latency);
      end
    end
    for (int i = 0; i < FLOAT_REGS; i++) begin
      float_wait_nxt[i] = is_illegal ? float_wait_r[i] : wait_dec(float_wait_r[i]);
      if (!stall && !is_illegal && in_dest_kind == DEST_FLOAT &&
          32'(in_dest_reg[4:1]) == i) begin
        float_wait_nxt[i] = wait_max(float_wait_nxt[i], in_result_latency);
      end
    end
    for (int i = 0; i < 2; i++) begin
      hilo_wait_nxt[i] = is_illegal ? hilo_wait_r[i] : wait_dec(hilo_wait_r[i]);
    end
    if (!stall && !is_illegal) begin
      if (in_dest_kind == DEST_HI || in_dest_kind == DEST_HILO) begin
        hilo_wait_nxt[0] = wait_max(hilo_wait_nxt[0], in_result_latency);
      end
      if (in_dest_kind == DEST_LO || in_dest_kind == DEST_HILO) begin
        hilo_wait_nxt[1] = wait_max(hilo_wait_nxt[1], in_result_latency);
      end
    end
    if (is_illegal)  load_in_execute_nxt = load_in_execute_r;
    else if (stall)  load_in_execute_nxt = 1'b0;
    else             load_in_execute_nxt = (in_mem_kind == MEM_LOAD);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < INT_REGS; i++)   int_wait_r[i]   <= 2'd0;
      for (int i = 0; i < FLOAT_REGS; i++) float_wait_r[i] <= 2'd0;
      for (int i = 0; i < 2; i++)          hilo_wait_r[i]  <= 2'd0;
      syscall_pending_r <= 1'b0;
      load_in_execute_r <= 1'b0;
    end else if (in_fire) begin
      int_wait_r        <= int_wait_nxt;
      float_wait_r      <= float_wait_nxt;
      hilo_wait_r       <= hilo_wait_nxt;
      syscall_pending_r <= syscall_pending_nxt;
      load_in_execute_r <= load_in_execute_nxt;
    end
  end

  // Two-entry result queue
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (in_fire)  wr_ptr_r <= !wr_ptr_r;
      if (out_fire) rd_ptr_r <= !rd_ptr_r;
      if (in_fire && !out_fire)      count_r <= count_r + 2'd1;
      else if (!in_fire && out_fire) count_r <= count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) fifo_r[wr_ptr_r] <= res;
  end

  assign out_stall_res    = fifo_r[rd_ptr_r].stall_res;
  assign out_src_a_select = fifo_r[rd_ptr_r].src_a_select;
  assign out_src_b_select = fifo_r[rd_ptr_r].src_b_select;
  assign out_sub_select   = fifo_r[rd_ptr_r].sub_select;
  assign out_bubble       = fifo_r[rd_ptr_r].bubble;
  assign out_squash_fetch = fifo_r[rd_ptr_r].squash_fetch;
  assign out_illegal      = fifo_r[rd_ptr_r].illegal;

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r != 2'd3)
    else $error("result queue count out of range");

  a_illegal_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_illegal |-> !out_stall_res && !out_squash_fetch &&
                                 out_src_a_select == SEL_REGFILE)
    else $error("illegal beat carries stall or select");

  a_squash_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_squash_fetch |-> out_stall_res && out_bubble)
    else $error("fetch squash without stall");

  a_syscall_sets: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_kind == KIND_SYSCALL && !syscall_pending_r |=> syscall_pending_r)
    else $error("new syscall did not set pending flag");

  a_stall_clears_load: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && stall |=> !load_in_execute_r)
    else $error("load flag survived a bubble");

endmodule
